FILE: design/battery_charge_estimator_defines.svh
// ----------------------------------------------------------------------------
// battery charge estimator assertion macros
// shared forms for the concurrent checks of the estimator
// ----------------------------------------------------------------------------
`ifndef BATTERY_CHARGE_ESTIMATOR_DEFINES_SVH
`define BATTERY_CHARGE_ESTIMATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bce_pkg.sv
// ----------------------------------------------------------------------------
// bce_pkg
// widths, register map, sequencer states and the li-ion ocv table
// ----------------------------------------------------------------------------
package bce_pkg;

  // payload widths
  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 16;
  localparam int PCT_W    = 7;
  localparam int RATIO_W  = 16;
  localparam int SUM_W    = 16;

  // batch length default
  localparam int SAMPLE_COUNT_DEF = 16;

  // fraction bits of the divider ratio
  localparam int RATIO_FRAC_W = 12;
  localparam int PROD_W       = SUM_W + RATIO_W;

  // shared divider sizing
  localparam int DIV_W  = PROD_W - RATIO_FRAC_W;
  localparam int DSR_W  = 8;
  localparam int STEP_W = $clog2(DIV_W);

  // percent arithmetic
  localparam int IDX_W = 4;
  localparam int NUM_W = 15;
  localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_EMPTY = '0;

  // apb register map
  localparam int DATA_W     = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_DIVIDER_RATIO = '0;
  localparam logic [RATIO_W-1:0]   RATIO_RESET       = RATIO_W'(8192);

  // open-circuit voltage points, 100 % down to 0 % in 10 % steps
  localparam int OCV_POINTS = 11;
  localparam int OCV_W      = 13;
  localparam logic [OCV_W-1:0] OCV_MV [OCV_POINTS] = '{
    13'd4190, 13'd4050, 13'd3990, 13'd3890, 13'd3800, 13'd3720,
    13'd3630, 13'd3530, 13'd3420, 13'd3300, 13'd3100
  };

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_V,
    ST_PCT,
    ST_DIV_P,
    ST_DONE
  } bce_state_t;

endpackage

FILE: design/bce_if.sv
// ----------------------------------------------------------------------------
// bce_if
// valid/ready channels for pin samples and for estimator results
// ----------------------------------------------------------------------------

// pin sample channel
interface bce_in_if;
  import bce_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_mv;

  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

// result channel
interface bce_out_if;
  import bce_pkg::*;

  logic             valid;
  logic             ready;
  logic [MV_W-1:0]  battery_mv;
  logic [PCT_W-1:0] charge_percent;

  modport source (output valid, output battery_mv, output charge_percent, input ready);
  modport sink   (input valid, input battery_mv, input charge_percent, output ready);
endinterface

FILE: design/battery_charge_estimator.sv
// ----------------------------------------------------------------------------
// battery_charge_estimator
// batch-averaged battery voltage and li-ion state of charge from pin samples
// ----------------------------------------------------------------------------
// Pin samples in mV are summed in batches of SAMPLE_COUNT; each sample that
// does not close a batch is added to the running sum. The sample that closes
// a batch starts the sequencer: the sum x divider_ratio product (ST_MUL), the
// divide by SAMPLE_COUNT as a multiply by its exact reciprocal (ST_DIV_V),
// the ocv band lookup (ST_PCT), the shared restoring divider for the
// interpolated percent (ST_DIV_P, skipped above the top or below the bottom
// point) and the load of the result register (ST_DONE); in_ready is low
// throughout. The load is held only while an earlier result beat is still
// unaccepted. The result sits in an output register, so samples of the next
// batch are taken while it waits.
// divider_ratio is written over APB at address 0.
module battery_charge_estimator #(
  parameter int SAMPLE_COUNT = bce_pkg::SAMPLE_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bce_in_if.sink                          in_ch,
  bce_out_if.source                       out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bce_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bce_pkg::DATA_W-1:0]      pwdata,
  output logic [bce_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import bce_pkg::*;

  localparam int CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_COUNT - 1);

  // reciprocal of the batch length, exact for every DIV_W-bit dividend
  localparam int RECIP_L = $clog2(SAMPLE_COUNT);
  localparam int RECIP_K = DIV_W + RECIP_L;
  localparam int RECIP_W = DIV_W + 1;
  localparam int RPROD_W = RECIP_K + DIV_W;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((1 << RECIP_K) + SAMPLE_COUNT - 1) / SAMPLE_COUNT);

  bce_state_t          state_r, state_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]    fin_sum_r, fin_sum_nxt;
  logic [RATIO_W-1:0]  ratio_r;
  logic [DIV_W-1:0]    div_q_r, div_q_nxt;
  logic [DSR_W-1:0]    div_rem_r, div_rem_nxt;
  logic [DSR_W-1:0]    divisor_r, divisor_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [MV_W-1:0]     volt_r, volt_nxt;
  logic [PCT_W-1:0]    pct_r, pct_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [MV_W-1:0]     out_mv_r, out_mv_nxt;
  logic [PCT_W-1:0]    out_pct_r, out_pct_nxt;

  logic                cfg_wr;
  logic [SUM_W-1:0]    acc_sum;
  logic [PROD_W-1:0]   product;
  logic [RPROD_W-1:0]  recip_prod;
  logic [DSR_W:0]      trial;
  logic                trial_ge;
  logic [DSR_W-1:0]    rem_step;
  logic [DIV_W-1:0]    q_step;
  logic                div_last;
  logic [MV_W-1:0]     volt_sat;
  logic [IDX_W-1:0]    band;
  logic [OCV_W-1:0]    band_lo, band_hi;
  logic [DSR_W-1:0]    span, frac;
  logic [NUM_W-1:0]    base, part, num;

  // apb register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[CFG_ADDR_W-1:2] == REG_DIVIDER_RATIO);

  always_comb begin
    if (paddr[CFG_ADDR_W-1:2] == REG_DIVIDER_RATIO) begin
      prdata = DATA_W'(ratio_r);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r <= RATIO_RESET;
    end else if (cfg_wr) begin
      ratio_r <= pwdata[RATIO_W-1:0];
    end
  end

  // handshakes and result port
  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.battery_mv     = out_mv_r;
  assign out_ch.charge_percent = out_pct_r;

  // accumulator and product
  assign acc_sum = sum_r + SUM_W'(in_ch.sample_mv);
  assign product = PROD_W'(fin_sum_r) * PROD_W'(ratio_r);

  // divide by the batch length through the reciprocal
  assign recip_prod = RPROD_W'(div_q_r) * RPROD_W'(RECIP_M);

  // one restoring divider step
  assign trial    = {div_rem_r, div_q_r[DIV_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor_r});
  assign rem_step = trial_ge ? DSR_W'(trial - {1'b0, divisor_r}) : trial[DSR_W-1:0];
  assign q_step   = {div_q_r[DIV_W-2:0], trial_ge};
  assign div_last = (step_r == STEP_W'(DIV_W - 1));

  // saturated voltage from the quotient
  assign volt_sat = (|div_q_r[DIV_W-1:MV_W]) ? '1 : div_q_r[MV_W-1:0];

  // ocv band search, lowest index that the voltage reaches
  always_comb begin
    band = IDX_W'(OCV_POINTS - 1);
    for (int i = OCV_POINTS - 1; i >= 1; i--) begin
      if (volt_sat >= MV_W'(OCV_MV[i])) begin
        band = IDX_W'(i);
      end
    end
  end

  // interpolation numerator
  assign band_lo = OCV_MV[band];
  assign band_hi = OCV_MV[band - IDX_W'(1)];
  assign span    = DSR_W'(band_hi - band_lo);
  assign frac    = DSR_W'(volt_sat - MV_W'(band_lo));
  assign base    = NUM_W'(IDX_W'(OCV_POINTS - 1) - band) * NUM_W'(span);
  assign part    = base + NUM_W'(frac);
  assign num     = (part << 3) + (part << 1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    fin_sum_nxt   = fin_sum_r;
    div_q_nxt     = div_q_r;
    div_rem_nxt   = div_rem_r;
    divisor_nxt   = divisor_r;
    step_nxt      = step_r;
    volt_nxt      = volt_r;
    pct_nxt       = pct_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_mv_nxt    = out_mv_r;
    out_pct_nxt   = out_pct_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (count_r == CNT_LAST) begin
            fin_sum_nxt = acc_sum;
            sum_nxt     = '0;
            count_nxt   = '0;
            state_nxt   = ST_MUL;
          end else begin
            sum_nxt   = acc_sum;
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ST_MUL: begin
        div_q_nxt = product[PROD_W-1:RATIO_FRAC_W];
        state_nxt = ST_DIV_V;
      end
      ST_DIV_V: begin
        div_q_nxt = recip_prod[RPROD_W-1:RECIP_K];
        state_nxt = ST_PCT;
      end
      ST_PCT: begin
        volt_nxt = volt_sat;
        if (volt_sat >= MV_W'(OCV_MV[0])) begin
          pct_nxt   = PCT_FULL;
          state_nxt = ST_DONE;
        end else if (volt_sat < MV_W'(OCV_MV[OCV_POINTS-1])) begin
          pct_nxt   = PCT_EMPTY;
          state_nxt = ST_DONE;
        end else begin
          div_q_nxt   = DIV_W'(num);
          div_rem_nxt = '0;
          divisor_nxt = span;
          step_nxt    = '0;
          state_nxt   = ST_DIV_P;
        end
      end
      ST_DIV_P: begin
        div_q_nxt   = q_step;
        div_rem_nxt = rem_step;
        step_nxt    = step_r + STEP_W'(1);
        if (div_last) begin
          pct_nxt   = q_step[PCT_W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_mv_nxt    = volt_r;
          out_pct_nxt   = pct_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sum_r       <= '0;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    fin_sum_r <= fin_sum_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    divisor_r <= divisor_nxt;
    volt_r    <= volt_nxt;
    pct_r     <= pct_nxt;
    out_mv_r  <= out_mv_nxt;
    out_pct_r <= out_pct_nxt;
  end

endmodule

FILE: design/bce_checker.sv
// ----------------------------------------------------------------------------
// bce_checker
// port-level checks of the estimator result channel
// ----------------------------------------------------------------------------
`include "battery_charge_estimator_defines.svh"

module bce_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [bce_pkg::MV_W-1:0]   out_mv,
  input logic [bce_pkg::PCT_W-1:0]  out_pct
);
  import bce_pkg::*;

  // a stalled result beat stays put
  `BCE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mv) && $stable(out_pct), "stalled result beat changed")

  // percent never exceeds full charge
  `BCE_ASSERT_NOW(a_pct_range, clk, rst_n, out_valid, out_pct <= PCT_FULL, "charge percent above 100")

  // at or above the top point the pack reads full
  `BCE_ASSERT_NOW(a_pct_full, clk, rst_n, out_valid && (out_mv >= MV_W'(OCV_MV[0])), out_pct == PCT_FULL, "full voltage without full charge")

  // below the bottom point the pack reads empty
  `BCE_ASSERT_NOW(a_pct_empty, clk, rst_n, out_valid && (out_mv < MV_W'(OCV_MV[OCV_POINTS-1])), out_pct == PCT_EMPTY, "low voltage without empty charge")

endmodule

bind battery_charge_estimator bce_checker u_bce_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_mv    (out_ch.battery_mv),
  .out_pct   (out_ch.charge_percent)
);
